// File: sv/cbpm_pkg.sv
// Shared types, constants and codes for the capture buffer pool manager.
package cbpm_pkg;

  localparam int BUFFER_COUNT = 4;
  localparam int CHUNK_SIZE   = 512;

  localparam int BUF_W   = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
  localparam int CNT_W   = $clog2(BUFFER_COUNT + 1);
  localparam int LEN_W   = $clog2(CHUNK_SIZE + 1);
  localparam int TOTAL_W = 23;
  localparam int START_W = 22;

  localparam logic [TOTAL_W-1:0] MAX_TOTAL   = 23'd4194304;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 23'd65536;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_CHUNK = 2'd1,
    OP_TICK  = 2'd2,
    OP_STOP  = 2'd3
  } opcode_t;

  localparam logic [1:0] CAP_NONE  = 2'd0;
  localparam logic [1:0] CAP_START = 2'd1;
  localparam logic [1:0] CAP_HALT  = 2'd2;

  typedef struct packed {
    opcode_t opcode;
    logic    write_finished;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         capture_cmd;
    logic [BUF_W-1:0]   capture_buffer;
    logic [LEN_W-1:0]   capture_length;
    logic               write_issue;
    logic [BUF_W-1:0]   write_buffer;
    logic [TOTAL_W-1:0] write_byte_address;
    logic [LEN_W-1:0]   write_length;
    logic               capturing;
    logic               overrun;
    logic               record_done;
    logic [TOTAL_W-1:0] recorded_samples;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_HOLD
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;
  } ctl_cmd_t;

endpackage

// File: sv/cbpm_if.sv
// Valid/ready channel interfaces for the input and result words.
interface cbpm_in_if;
  import cbpm_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cbpm_out_if;
  import cbpm_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/capture_buffer_pool_manager.sv
// Capture buffer pool manager: a controller accepts one word per cycle and the datapath
// updates the buffer pool, the chunk queue and the storage write state in that same
// cycle, placing the result word in an output register. The result is offered the
// cycle after its input word is accepted; a new word is accepted in the cycle the
// pending result is taken, so the block sustains one word per cycle when the result
// side is ready. The datapath state being updated in the accepting cycle sets that figure.
// The user must write the recording's sample total through cfg_we/cfg_wdata only
// while the block is idle; the block itself does not enforce it.
module capture_buffer_pool_manager (
  input  logic                         clk,
  input  logic                         rst_n,
  cbpm_in_if.sink                      in_chan,
  cbpm_out_if.source                   out_chan,
  input  logic                         cfg_we,
  input  logic [cbpm_pkg::TOTAL_W-1:0] cfg_wdata
);
  import cbpm_pkg::*;

  ctl_cmd_t cmd;

  cbpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  cbpm_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_chan.data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_item  (out_chan.data)
  );

endmodule

// File: sv/cbpm_ctrl.sv
// Handshake controller: accepts a word, holds the result until it is taken.
module cbpm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output cbpm_pkg::ctl_cmd_t cmd
);
  import cbpm_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready && !in_valid) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_HOLD: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
      end
      default: in_ready = 1'b0;
    endcase
    cmd.exec = in_valid && in_ready;
  end

endmodule

// File: sv/cbpm_datapath.sv
// Buffer pool, chunk queue, write tracking and the registered result word.
module cbpm_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cbpm_pkg::ctl_cmd_t               cmd,
  input  cbpm_pkg::in_item_t               in_item,
  input  logic                             cfg_we,
  input  logic [cbpm_pkg::TOTAL_W-1:0]     cfg_wdata,
  output cbpm_pkg::out_item_t              out_item
);
  import cbpm_pkg::*;

  logic [TOTAL_W-1:0] total_r;

  logic [BUFFER_COUNT-1:0] buffer_free_r, buffer_free_nxt;
  logic [BUF_W-1:0]   q_buffer [BUFFER_COUNT];
  logic [START_W-1:0] q_start  [BUFFER_COUNT];
  logic [LEN_W-1:0]   q_length [BUFFER_COUNT];
  logic [BUF_W-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [BUF_W-1:0]   active_buffer_r, active_buffer_nxt;
  logic [START_W-1:0] active_start_r, active_start_nxt;
  logic [LEN_W-1:0]   active_length_r, active_length_nxt;
  logic [TOTAL_W-1:0] started_r, started_nxt;
  logic               running_r, running_nxt;
  logic               overrun_r, overrun_nxt;
  logic               busy_r, busy_nxt;
  logic [BUF_W-1:0]   held_buffer_r, held_buffer_nxt;
  logic [START_W-1:0] held_start_r, held_start_nxt;
  logic [LEN_W-1:0]   held_length_r, held_length_nxt;
  logic [TOTAL_W-1:0] committed_r, committed_nxt;
  out_item_t          out_r, out_nxt;

  logic [TOTAL_W-1:0]      total_eff;
  logic                    is_start;
  logic [BUFFER_COUNT-1:0] free_base;
  logic [TOTAL_W-1:0]      started_base;
  logic                    found;
  logic [BUF_W-1:0]        pick;
  logic [TOTAL_W-1:0]      remain;
  logic [LEN_W-1:0]        chunk_len;
  logic [TOTAL_W-1:0]      held_end;
  logic                    q_we;
  logic                    do_claim;
  logic [1:0]              cap_cmd;
  logic                    w_issue;

  assign total_eff    = (total_r > MAX_TOTAL) ? MAX_TOTAL : total_r;
  assign is_start     = (in_item.opcode == OP_START);
  assign free_base    = is_start ? {BUFFER_COUNT{1'b1}} : buffer_free_r;
  assign started_base = is_start ? '0 : started_r;
  assign remain       = total_eff - started_base;
  assign chunk_len    = (remain > TOTAL_W'(CHUNK_SIZE)) ? LEN_W'(CHUNK_SIZE)
                                                         : remain[LEN_W-1:0];
  assign held_end     = {1'b0, held_start_r} + TOTAL_W'(held_length_r);

  // lowest free buffer
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int i = BUFFER_COUNT - 1; i >= 0; i--) begin
      if (free_base[i]) begin
        found = 1'b1;
        pick  = BUF_W'(i);
      end
    end
  end

  always_comb begin
    buffer_free_nxt   = buffer_free_r;
    head_nxt          = head_r;
    tail_nxt          = tail_r;
    count_nxt         = count_r;
    active_buffer_nxt = active_buffer_r;
    active_start_nxt  = active_start_r;
    active_length_nxt = active_length_r;
    started_nxt       = started_r;
    running_nxt       = running_r;
    overrun_nxt       = overrun_r;
    busy_nxt          = busy_r;
    held_buffer_nxt   = held_buffer_r;
    held_start_nxt    = held_start_r;
    held_length_nxt   = held_length_r;
    committed_nxt     = committed_r;
    q_we              = 1'b0;
    do_claim          = 1'b0;
    cap_cmd           = CAP_NONE;
    w_issue           = 1'b0;
    out_nxt           = '0;

    case (in_item.opcode)
      OP_START: begin
        buffer_free_nxt   = {BUFFER_COUNT{1'b1}};
        head_nxt          = '0;
        tail_nxt          = '0;
        count_nxt         = '0;
        active_buffer_nxt = '0;
        active_start_nxt  = '0;
        active_length_nxt = '0;
        started_nxt       = '0;
        running_nxt       = 1'b0;
        overrun_nxt       = 1'b0;
        busy_nxt          = 1'b0;
        held_buffer_nxt   = '0;
        held_start_nxt    = '0;
        held_length_nxt   = '0;
        committed_nxt     = '0;
        do_claim          = 1'b1;
      end
      OP_CHUNK: begin
        if (running_r) begin
          if (count_r >= CNT_W'(BUFFER_COUNT)) begin
            overrun_nxt = 1'b1;
            running_nxt = 1'b0;
            cap_cmd     = CAP_HALT;
          end else begin
            q_we      = 1'b1;
            tail_nxt  = (tail_r == BUF_W'(BUFFER_COUNT - 1)) ? '0 : tail_r + 1'b1;
            count_nxt = count_r + 1'b1;
            do_claim  = 1'b1;
          end
        end
      end
      OP_TICK: begin
        // retire the finished write before issuing the next one
        if (busy_r && in_item.write_finished) begin
          busy_nxt                       = 1'b0;
          buffer_free_nxt[held_buffer_r] = 1'b1;
          if (held_end > committed_r) committed_nxt = held_end;
        end
        if ((!busy_r || in_item.write_finished) && count_r != '0) begin
          held_buffer_nxt = q_buffer[head_r];
          held_start_nxt  = q_start[head_r];
          held_length_nxt = q_length[head_r];
          head_nxt        = (head_r == BUF_W'(BUFFER_COUNT - 1)) ? '0 : head_r + 1'b1;
          count_nxt       = count_r - 1'b1;
          busy_nxt        = 1'b1;
          w_issue         = 1'b1;
        end
      end
      OP_STOP: begin
        running_nxt = 1'b0;
        cap_cmd     = CAP_HALT;
      end
      default: cap_cmd = CAP_NONE;
    endcase

    if (do_claim) begin
      if (started_base >= total_eff) begin
        running_nxt = 1'b0;
        cap_cmd     = CAP_HALT;
      end else if (!found) begin
        overrun_nxt = 1'b1;
        running_nxt = 1'b0;
        cap_cmd     = CAP_HALT;
      end else begin
        buffer_free_nxt[pick] = 1'b0;
        active_buffer_nxt     = pick;
        active_start_nxt      = started_base[START_W-1:0];
        active_length_nxt     = chunk_len;
        started_nxt           = started_base + TOTAL_W'(chunk_len);
        running_nxt           = 1'b1;
        cap_cmd               = CAP_START;
      end
    end

    out_nxt.capture_cmd = cap_cmd;
    if (cap_cmd == CAP_START) begin
      out_nxt.capture_buffer = active_buffer_nxt;
      out_nxt.capture_length = active_length_nxt;
    end
    if (w_issue) begin
      out_nxt.write_issue        = 1'b1;
      out_nxt.write_buffer       = held_buffer_nxt;
      out_nxt.write_byte_address = {held_start_nxt, 1'b0};
      out_nxt.write_length       = held_length_nxt;
    end
    out_nxt.capturing        = running_nxt;
    out_nxt.overrun          = overrun_nxt;
    out_nxt.record_done      = !running_nxt && (started_nxt >= total_eff) &&
                               (count_nxt == '0) && !busy_nxt;
    out_nxt.recorded_samples = committed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= TOTAL_RESET;
    end else if (cfg_we) begin
      total_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_free_r   <= {BUFFER_COUNT{1'b1}};
      head_r          <= '0;
      tail_r          <= '0;
      count_r         <= '0;
      active_buffer_r <= '0;
      active_start_r  <= '0;
      active_length_r <= '0;
      started_r       <= '0;
      running_r       <= 1'b0;
      overrun_r       <= 1'b0;
      busy_r          <= 1'b0;
      held_buffer_r   <= '0;
      held_start_r    <= '0;
      held_length_r   <= '0;
      committed_r     <= '0;
    end else if (cmd.exec) begin
      buffer_free_r   <= buffer_free_nxt;
      head_r          <= head_nxt;
      tail_r          <= tail_nxt;
      count_r         <= count_nxt;
      active_buffer_r <= active_buffer_nxt;
      active_start_r  <= active_start_nxt;
      active_length_r <= active_length_nxt;
      started_r       <= started_nxt;
      running_r       <= running_nxt;
      overrun_r       <= overrun_nxt;
      busy_r          <= busy_nxt;
      held_buffer_r   <= held_buffer_nxt;
      held_start_r    <= held_start_nxt;
      held_length_r   <= held_length_nxt;
      committed_r     <= committed_nxt;
    end
  end

  // chunk queue storage
  always_ff @(posedge clk) begin
    if (cmd.exec && q_we) begin
      q_buffer[tail_r] <= active_buffer_r;
      q_start[tail_r]  <= active_start_r;
      q_length[tail_r] <= active_length_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_r <= out_nxt;
    end
  end

  assign out_item = out_r;

endmodule
